// ===== sv/text_stream_line_number_filter_macros.svh =====
// Assertion helpers for the line number filter
`ifndef TEXT_STREAM_LINE_NUMBER_FILTER_MACROS_SVH
`define TEXT_STREAM_LINE_NUMBER_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define TSLN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define TSLN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define TSLN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TSLN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/tsln_pkg.sv =====
`timescale 1ns / 1ps

package tsln_pkg;

  localparam int NumberWidthDefault = 6;
  // line counter is kept in BCD; it saturates at 999999
  localparam int CntDigits = 6;
  localparam int SufMax = 4;
  localparam int QueueDepth = 2;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_FLIP = 8'h40;

  typedef enum logic [2:0] {
    REG_NUMBER_ALL,
    REG_NUMBER_NONBLANK,
    REG_SQUEEZE_BLANK,
    REG_SHOW_TABS,
    REG_SHOW_NONPRINTING,
    REG_SHOW_ENDS
  } reg_idx_e;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank;
    logic show_tabs;
    logic show_nonprinting;
    logic show_ends;
  } cfg_t;

  // one classified input byte: optional number prefix plus 1..4 trailing bytes
  typedef struct packed {
    logic                          num_en;
    logic [CntDigits-1:0][3:0]     digits;
    logic [2:0]                    num_digits;
    logic [SufMax-1:0][7:0]        suf;
    logic [2:0]                    suf_len;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/tsln_front.sv =====
`timescale 1ns / 1ps

module tsln_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsln_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output tsln_pkg::item_t   item_o
);

  logic [tsln_pkg::CntDigits-1:0][3:0] cnt_q, cnt_d, cnt_inc;
  logic       line_start_q, line_start_d;
  logic [1:0] blank_run_q, blank_run_d, br_next;
  logic       accept, squeeze_hit, drop, num_en, carry, all_nines;
  logic [7:0] ch;
  logic [2:0] n;
  logic [2:0] nd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // saturating BCD increment
  always_comb begin
    cnt_inc   = cnt_q;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int i = 0; i < tsln_pkg::CntDigits; i++) begin
      if (cnt_q[i] != 4'd9) all_nines = 1'b0;
      if (carry) begin
        if (cnt_q[i] == 4'd9) begin
          cnt_inc[i] = 4'd0;
        end else begin
          cnt_inc[i] = cnt_q[i] + 4'd1;
          carry      = 1'b0;
        end
      end
    end
    if (all_nines) cnt_inc = cnt_q;
  end

  // significant digit count, at least one
  always_comb begin
    nd = 3'd1;
    for (int i = 0; i < tsln_pkg::CntDigits; i++) begin
      if (cnt_q[i] != 4'd0) nd = 3'(i + 1);
    end
  end

  always_comb begin
    squeeze_hit = cfg_i.squeeze_blank && line_start_q && (in_byte_i == tsln_pkg::CH_NL);
    drop        = 1'b0;
    if (squeeze_hit) begin
      br_next = (blank_run_q < 2'd2) ? blank_run_q + 2'd1 : blank_run_q;
      drop    = (br_next > 2'd1);
    end else begin
      br_next = 2'd0;
    end

    if (cfg_i.number_nonblank_lines) begin
      num_en = line_start_q && (in_byte_i != tsln_pkg::CH_NL);
    end else begin
      num_en = cfg_i.number_all_lines && line_start_q;
    end

    blank_run_d  = blank_run_q;
    line_start_d = line_start_q;
    cnt_d        = cnt_q;
    if (accept) begin
      blank_run_d = br_next;
      if (!drop) begin
        line_start_d = (in_byte_i == tsln_pkg::CH_NL);
        if (num_en) cnt_d = cnt_inc;
      end
    end
  end

  // character part: caret / M- notation, tab and end marks
  always_comb begin
    item_o.num_en     = num_en;
    item_o.digits     = cnt_q;
    item_o.num_digits = nd;
    item_o.suf = '0;
    ch = in_byte_i;
    n  = 3'd0;
    if (cfg_i.show_tabs && ch == tsln_pkg::CH_TAB) begin
      item_o.suf[n[1:0]] = tsln_pkg::CH_CARET;
      n  = n + 3'd1;
      ch = tsln_pkg::CH_I;
    end
    if (cfg_i.show_nonprinting && ch != tsln_pkg::CH_NL && ch != tsln_pkg::CH_TAB) begin
      if (ch[7]) begin
        item_o.suf[n[1:0]] = tsln_pkg::CH_M;
        item_o.suf[2'(n + 3'd1)] = tsln_pkg::CH_DASH;
        n     = n + 3'd2;
        ch[7] = 1'b0;
      end
      if (ch < 8'd32 || ch == tsln_pkg::CH_DEL) begin
        item_o.suf[n[1:0]] = tsln_pkg::CH_CARET;
        n  = n + 3'd1;
        ch = ch ^ tsln_pkg::CTRL_FLIP;
      end
    end
    if (cfg_i.show_ends && ch == tsln_pkg::CH_NL) begin
      item_o.suf[n[1:0]] = tsln_pkg::CH_DOLLAR;
      n = n + 3'd1;
    end
    item_o.suf[n[1:0]] = ch;
    item_o.suf_len     = n + 3'd1;
  end

  assign push_o = accept && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= {{(tsln_pkg::CntDigits-1){4'd0}}, 4'd1};
      line_start_q <= 1'b1;
      blank_run_q  <= 2'd0;
    end else begin
      cnt_q        <= cnt_d;
      line_start_q <= line_start_d;
      blank_run_q  <= blank_run_d;
    end
  end

endmodule

// ===== sv/tsln_queue.sv =====
`timescale 1ns / 1ps

module tsln_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsln_pkg::item_t   item_i,
  input  logic              pop_i,
  output tsln_pkg::item_t   item_o,
  output tsln_pkg::q_stat_t stat_o
);

  localparam int PtrW = $clog2(tsln_pkg::QueueDepth);
  localparam int CntW = $clog2(tsln_pkg::QueueDepth + 1);

  tsln_pkg::item_t mem_q [tsln_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == CntW'(tsln_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/tsln_back.sv =====
`timescale 1ns / 1ps

module tsln_back #(
  parameter int NUMBER_WIDTH = tsln_pkg::NumberWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsln_pkg::item_t   item_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);

  localparam int FieldMax = (NUMBER_WIDTH > tsln_pkg::CntDigits) ?
                            NUMBER_WIDTH : tsln_pkg::CntDigits;
  localparam int PosW     = $clog2(FieldMax + 1 + tsln_pkg::SufMax + 1);
  localparam int SufW     = $clog2(tsln_pkg::SufMax);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] nd, field, num_len, total, digit_pos, suf_pos;
  logic [3:0]      digit;
  logic [7:0]      byte_d, out_byte_q;
  logic            last_pos, load, out_valid_q, out_last_q;

  always_comb begin
    nd        = PosW'(item_i.num_digits);
    field     = (nd > PosW'(NUMBER_WIDTH)) ? nd : PosW'(NUMBER_WIDTH);
    num_len   = item_i.num_en ? field + PosW'(1) : '0;
    total     = num_len + PosW'(item_i.suf_len);
    digit_pos = field - PosW'(1) - pos_q;
    suf_pos   = pos_q - num_len;
    digit     = 4'd0;
    if (digit_pos < PosW'(tsln_pkg::CntDigits)) digit = item_i.digits[digit_pos[2:0]];

    if (pos_q < num_len) begin
      if (pos_q == field) begin
        byte_d = tsln_pkg::CH_TAB;
      end else if (pos_q < field - nd) begin
        byte_d = tsln_pkg::CH_SPACE;
      end else begin
        byte_d = tsln_pkg::CH_ZERO + {4'd0, digit};
      end
    end else begin
      byte_d = item_i.suf[suf_pos[SufW-1:0]];
    end
    last_pos = (pos_q == total - PosW'(1));
  end

  assign load  = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last_pos;
  assign pos_d = load ? (last_pos ? '0 : pos_q + PosW'(1)) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_d;
      out_last_q <= last_pos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== sv/text_stream_line_number_filter.sv =====
`timescale 1ns / 1ps

// Text filter in the style of cat -b -n -s -t -v -e: each input byte yields
// zero or more output beats; the final beat of a byte has last_of_run_o set.
// Output runs at one beat per cycle while out_ready_i is high. A plain
// byte yields one beat; a byte that expands into a line number, caret or
// M- notation or a '$' yields one beat per output character (up to
// max(NUMBER_WIDTH, 6) + 5), and the input is accepted every cycle while
// the two-entry queue between the classifier and the expander has room.
// A squeezed empty line produces no beats. Line numbers saturate at 999999.
// Registers (APB, byte address 4*i, bit 0): 0 number all lines, 1 number
// non-empty lines (wins over 0), 2 squeeze blank lines, 3 show tabs,
// 4 show non-printing, 5 show ends. Write them only while the block is idle.

`include "text_stream_line_number_filter_macros.svh"

module text_stream_line_number_filter #(
  parameter int NUMBER_WIDTH = tsln_pkg::NumberWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);

  tsln_pkg::cfg_t    cfg_q;
  tsln_pkg::item_t   push_item, head_item;
  tsln_pkg::q_stat_t q_stat;
  tsln_pkg::reg_idx_e reg_idx;
  logic push, pop, cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = tsln_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        tsln_pkg::REG_NUMBER_ALL:       cfg_q.number_all_lines      <= pwdata[0];
        tsln_pkg::REG_NUMBER_NONBLANK:  cfg_q.number_nonblank_lines <= pwdata[0];
        tsln_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank         <= pwdata[0];
        tsln_pkg::REG_SHOW_TABS:        cfg_q.show_tabs             <= pwdata[0];
        tsln_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting      <= pwdata[0];
        tsln_pkg::REG_SHOW_ENDS:        cfg_q.show_ends             <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      tsln_pkg::REG_NUMBER_ALL:       prdata[0] = cfg_q.number_all_lines;
      tsln_pkg::REG_NUMBER_NONBLANK:  prdata[0] = cfg_q.number_nonblank_lines;
      tsln_pkg::REG_SQUEEZE_BLANK:    prdata[0] = cfg_q.squeeze_blank;
      tsln_pkg::REG_SHOW_TABS:        prdata[0] = cfg_q.show_tabs;
      tsln_pkg::REG_SHOW_NONPRINTING: prdata[0] = cfg_q.show_nonprinting;
      tsln_pkg::REG_SHOW_ENDS:        prdata[0] = cfg_q.show_ends;
      default:                        prdata    = '0;
    endcase
  end

  tsln_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .item_o     (push_item)
  );

  tsln_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  tsln_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (head_item),
    .q_empty_i     (q_stat.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // nothing can appear at the output without a queued item behind it
  `TSLN_ASSERT_NEXT(a_no_beat_from_empty, clk_i, rst_ni, q_stat.empty && !out_valid_o, !out_valid_o)
  // an item pushed into the queue is still pending in the next cycle
  `TSLN_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push, !q_stat.empty)
  // an item leaves the queue only with its final beat
  `TSLN_ASSERT_NEXT(a_pop_marks_last, clk_i, rst_ni, pop, out_valid_o && last_of_run_o)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int          NUM_W     = tsln_pkg::NumberWidthDefault;
  localparam int unsigned COUNT_MAX = 999999;
  // worst-case beats still in flight after the last expected one has come
  localparam int          DRAIN     = 2 * (NUM_W + 5) + 8;
  localparam int          PHASE_LEN = 92;
  localparam int          N_PHASES  = 5;
  localparam logic [4:0]  ADDR_UNUSED = 5'd24;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [4:0] addr;
    logic [7:0] data;
    logic       has_exp;
    logic [7:0] exp_ch;
  } dir_row_t;

  localparam int N_DIR = 33;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // everything off after reset: bytes pass through
    '{ROW_BYTE, 5'd0, 8'h41, 1'b1, 8'h41},
    '{ROW_BYTE, 5'd0, 8'h00, 1'b1, 8'h00},
    '{ROW_BYTE, 5'd0, 8'hFF, 1'b1, 8'hFF},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b1, 8'h0A},
    '{ROW_BYTE, 5'd0, 8'h09, 1'b1, 8'h09},
    '{ROW_CFG,  {tsln_pkg::REG_NUMBER_ALL, 2'b00}, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h78, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    // both numbering modes: empty lines stay unnumbered
    '{ROW_CFG,  {tsln_pkg::REG_NUMBER_NONBLANK, 2'b00}, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h79, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    // blank run: first kept, rest dropped
    '{ROW_CFG,  {tsln_pkg::REG_SQUEEZE_BLANK, 2'b00}, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_CFG,  {tsln_pkg::REG_SHOW_TABS, 2'b00}, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h09, 1'b0, 8'h00},
    '{ROW_CFG,  {tsln_pkg::REG_SHOW_NONPRINTING, 2'b00}, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h7F, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h80, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h89, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h1F, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'hA0, 1'b0, 8'h00},
    '{ROW_CFG,  {tsln_pkg::REG_SHOW_ENDS, 2'b00}, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h8A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    // write beyond the register file, must not disturb anything
    '{ROW_CFG,  ADDR_UNUSED, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h5A, 1'b0, 8'h00},
    '{ROW_BYTE, 5'd0, 8'h0A, 1'b0, 8'h00}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;

  // filter state mirror
  tsln_pkg::cfg_t mode;
  int unsigned    line_no;
  logic [7:0]     last_char;
  logic [1:0]     blank_cnt;

  beat_t       step_beats[$];
  beat_t       pending_beats[$];
  int          err_cnt;
  bit          idle_on;
  int          nl_burst;

  text_stream_line_number_filter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic emit_beat(input logic [7:0] ch, input logic last);
    beat_t b;
    b.ch   = ch;
    b.last = last;
    step_beats.push_back(b);
  endtask

  task automatic emit_line_no();
    logic [3:0]  digs [10];
    int          nd;
    int          pad;
    int unsigned v;
    nd = 0;
    v  = (line_no > COUNT_MAX) ? COUNT_MAX : line_no;
    do begin
      digs[nd] = 4'(v % 10);
      v        = v / 10;
      nd++;
    end while (v != 0 && nd < 10);
    for (pad = NUM_W - nd; pad > 0; pad--) emit_beat(tsln_pkg::CH_SPACE, 1'b0);
    while (nd > 0) begin
      nd--;
      emit_beat(8'(tsln_pkg::CH_ZERO + digs[nd]), 1'b0);
    end
    emit_beat(tsln_pkg::CH_TAB, 1'b0);
    line_no = (line_no < COUNT_MAX) ? line_no + 1 : COUNT_MAX;
  endtask

  // beats produced by one input byte, left in step_beats
  task automatic filter_step(input logic [7:0] c_in);
    logic [7:0] c;
    bit         at_bol;
    c      = c_in;
    at_bol = (last_char == tsln_pkg::CH_NL);
    step_beats.delete();
    if (mode.squeeze_blank && at_bol && c == tsln_pkg::CH_NL) begin
      if (blank_cnt < 2) blank_cnt++;
      if (blank_cnt > 1) return;
    end else begin
      blank_cnt = 2'd0;
    end
    if (mode.number_nonblank_lines) begin
      if (at_bol && c != tsln_pkg::CH_NL) emit_line_no();
    end else if (mode.number_all_lines) begin
      if (at_bol) emit_line_no();
    end
    if (mode.show_tabs && c == tsln_pkg::CH_TAB) begin
      emit_beat(tsln_pkg::CH_CARET, 1'b0);
      c = tsln_pkg::CH_I;
    end
    if (mode.show_nonprinting && c != tsln_pkg::CH_NL && c != tsln_pkg::CH_TAB) begin
      if (c >= 8'd128) begin
        c = c - 8'd128;
        emit_beat(tsln_pkg::CH_M, 1'b0);
        emit_beat(tsln_pkg::CH_DASH, 1'b0);
      end
      if (c < 8'd32 || c == tsln_pkg::CH_DEL) begin
        c = c ^ tsln_pkg::CTRL_FLIP;
        emit_beat(tsln_pkg::CH_CARET, 1'b0);
      end
    end
    if (mode.show_ends && c == tsln_pkg::CH_NL) emit_beat(tsln_pkg::CH_DOLLAR, 1'b0);
    last_char = c;
    emit_beat(c, 1'b1);
  endtask

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 8);
    return 0;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic queue_and_send(input logic [7:0] b);
    filter_step(b);
    foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
    send_byte(b);
  endtask

  // input side quiet and every expected beat delivered
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [4:0] addr, input logic val);
    logic [31:0] data;
    data    = $urandom;
    data[0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    if (addr[1:0] == 2'b00) begin
      case (addr[4:2])
        tsln_pkg::REG_NUMBER_ALL:       mode.number_all_lines      = val;
        tsln_pkg::REG_NUMBER_NONBLANK:  mode.number_nonblank_lines = val;
        tsln_pkg::REG_SQUEEZE_BLANK:    mode.squeeze_blank         = val;
        tsln_pkg::REG_SHOW_TABS:        mode.show_tabs             = val;
        tsln_pkg::REG_SHOW_NONPRINTING: mode.show_nonprinting      = val;
        tsln_pkg::REG_SHOW_ENDS:        mode.show_ends             = val;
        default: ;
      endcase
    end
  endtask

  task automatic apply_mode(input tsln_pkg::cfg_t m);
    write_reg({tsln_pkg::REG_NUMBER_ALL, 2'b00},       m.number_all_lines);
    write_reg({tsln_pkg::REG_NUMBER_NONBLANK, 2'b00},  m.number_nonblank_lines);
    write_reg({tsln_pkg::REG_SQUEEZE_BLANK, 2'b00},    m.squeeze_blank);
    write_reg({tsln_pkg::REG_SHOW_TABS, 2'b00},        m.show_tabs);
    write_reg({tsln_pkg::REG_SHOW_NONPRINTING, 2'b00}, m.show_nonprinting);
    write_reg({tsln_pkg::REG_SHOW_ENDS, 2'b00},        m.show_ends);
  endtask

  // mostly text lines, with blank-line runs, tabs and some binary noise
  function automatic logic [7:0] next_text_byte();
    int r;
    if (nl_burst > 0) begin
      nl_burst--;
      return tsln_pkg::CH_NL;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(32, 126));
    if (r < 70) begin
      if ($urandom_range(0, 3) == 0) nl_burst = $urandom_range(1, 3);
      return tsln_pkg::CH_NL;
    end
    if (r < 76) return tsln_pkg::CH_TAB;
    if (r < 84) return 8'($urandom_range(0, 31));
    if (r < 90) begin
      return ($urandom_range(0, 1) != 0) ? tsln_pkg::CH_DEL : 8'($urandom_range(128, 255));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // ready idles in bursts while idling is enabled
  initial begin
    int   hold;
    logic rdy;
    hold = 0;
    rdy  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        if (idle_on && $urandom_range(0, 2) == 0) begin
          rdy  = 1'b0;
          hold = $urandom_range(1, 8);
        end else begin
          rdy  = 1'b1;
          hold = $urandom_range(1, 12);
        end
      end
      out_ready_i <= rdy;
      hold--;
    end
  end

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat out_byte=%h last_of_run=%b", $time, out_byte_o,
                 last_of_run_o);
      end else begin
        want = pending_beats.pop_front();
        if (out_byte_o !== want.ch) begin
          err_cnt++;
          $display("%0t: out_byte expected %h actual %h", $time, want.ch, out_byte_o);
        end
        if (last_of_run_o !== want.last) begin
          err_cnt++;
          $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                   last_of_run_o);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    tsln_pkg::cfg_t m;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    out_ready_i = 1'b0;
    err_cnt     = 0;
    idle_on     = 1'b1;
    nl_burst    = 0;
    mode        = '0;
    line_no     = 1;
    last_char   = tsln_pkg::CH_NL;
    blank_cnt   = 2'd0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        settle();
        write_reg(DIR_TAB[i].addr, DIR_TAB[i].data[0]);
      end else if (DIR_TAB[i].has_exp) begin
        filter_step(DIR_TAB[i].data);
        if (step_beats.size() != 1 || step_beats[0].ch != DIR_TAB[i].exp_ch) begin
          err_cnt++;
          $display("%0t: row %0d expected %h actual %h", $time, i, DIR_TAB[i].exp_ch,
                   (step_beats.size() != 0) ? step_beats[0].ch : 8'h00);
        end
        pending_beats.push_back(beat_t'{DIR_TAB[i].exp_ch, 1'b1});
        send_byte(DIR_TAB[i].data);
      end else begin
        queue_and_send(DIR_TAB[i].data);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       m = '1;
        1:       m = '0;
        default: m = tsln_pkg::cfg_t'($urandom_range(0, 63));
      endcase
      idle_on = (p != 1) && (p != N_PHASES - 1);
      settle();
      apply_mode(m);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // one mid-phase pause with the output fully drained
        if (p == 2 && n == PHASE_LEN / 2) begin
          in_valid_i <= 1'b0;
          do @(negedge clk_i); while (pending_beats.size() != 0);
        end
        queue_and_send(next_text_byte());
      end
    end

    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tsln_pkg.sv
sv/tsln_front.sv
sv/tsln_queue.sv
sv/tsln_back.sv
sv/text_stream_line_number_filter.sv
tb/tb_top.sv
